[rtl/core/lcmt_pkg.sv]
// Shared types, constants and codes of the Li Chao minimum line tree.
`default_nettype none
package lcmt_pkg;

  localparam int XBITS = 12;
  localparam int QXW   = 12;
  localparam int CFGW  = 12;
  localparam int CW    = (XBITS > QXW) ? XBITS : QXW;
  localparam int AW    = XBITS + 1;
  localparam int SW    = 32;
  localparam int BW    = 64;
  localparam int VW    = 65;

  localparam logic [BW-1:0] IDENT = 64'h3f2f1f0f3f2f1f0f;

  localparam logic CFG_RANGE_LOW  = 1'b0;
  localparam logic CFG_RANGE_HIGH = 1'b1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_IRD,
    S_IDAT,
    S_EVP,
    S_EVQ,
    S_W1,
    S_CMP,
    S_QRD,
    S_QDAT,
    S_QW1,
    S_QCMP,
    S_QOUT
  } state_t;

  typedef enum logic [1:0] {
    PT_L,
    PT_R,
    PT_M
  } point_t;

  typedef struct packed {
    logic                 empty;
    logic signed [SW-1:0] slope;
    logic [BW-1:0]        intercept;
  } node_t;

endpackage
`default_nettype wire

[rtl/core/lcmt_req_if.sv]
// Request channel carrying one tree operation and its operands.
`default_nettype none
interface lcmt_req_if;
  import lcmt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic signed [SW-1:0] slope;
  logic signed [BW-1:0] intercept;
  logic [QXW-1:0]       query_x;

  modport source (output valid, op, slope, intercept, query_x, input ready);
  modport sink (input valid, op, slope, intercept, query_x, output ready);
endinterface
`default_nettype wire

[rtl/core/lcmt_rsp_if.sv]
// Response channel carrying one query minimum.
`default_nettype none
interface lcmt_rsp_if;
  import lcmt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [BW-1:0] low_value;

  modport source (output valid, low_value, input ready);
  modport sink (input valid, low_value, output ready);
endinterface
`default_nettype wire

[rtl/core/lcmt_line_eval.sv]
// Two-stage pipelined line evaluator computing slope*x + intercept exactly.
`default_nettype none
module lcmt_line_eval (
  input  logic                          clk,
  input  logic signed [lcmt_pkg::SW-1:0] a,
  input  logic [lcmt_pkg::BW-1:0]        b,
  input  logic [lcmt_pkg::CW-1:0]        x,
  output logic signed [lcmt_pkg::VW-1:0] value
);
  import lcmt_pkg::*;

  logic signed [SW+CW:0] prod;
  logic [BW-1:0]         b_d;

  always_ff @(posedge clk) begin
    prod  <= a * $signed({1'b0, x});
    b_d   <= b;
    value <= VW'($signed(b_d)) + VW'(prod);
  end
endmodule
`default_nettype wire

[rtl/core/li_chao_min_line_tree_core.sv]
// Top level of the Li Chao minimum line tree with its node memory and sequencer.
//
// Operations arrive on the req channel and transfer when valid and ready are
// both high. Ready is high only while the sequencer is idle. An insert walks
// the tree one level at a time; each level reads the node, and an empty node
// takes the line and ends the insert. A node that holds a line costs up to 3
// comparisons on the shared line evaluator; an insert visits at most 13 levels.
// A query reads and evaluates the node at each level of its walk, then loads
// the result register. A clear sweeps the node memory one entry per cycle,
// and the same sweep runs after reset before the first operation is taken.
// Only a query gives a result, on the rsp channel, saturated to 64 bits.
// The result register holds its value until the receiver takes it, and the
// block keeps taking inserts and clears meanwhile; a further query waits in
// its last step until the pending result has been transferred.
// Range registers are written through cfg_we, cfg_index and cfg_data; the user
// must do so only while the block is idle, as the block does not enforce it.
`default_nettype none
module li_chao_min_line_tree_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [lcmt_pkg::CFGW-1:0]   cfg_data,
  lcmt_req_if.sink                    req,
  lcmt_rsp_if.source                  rsp
);
  import lcmt_pkg::*;

  state_t state, state_next;
  point_t pt;

  logic [XBITS-1:0] range_low, range_high, root_hi;
  logic [XBITS-1:0] lo, hi, mid, mid_inc;
  logic [XBITS:0]   mid_sum;
  logic [AW-1:0]    idx, child;
  logic             child_ovf, go_right;
  logic [QXW-1:0]   qx;

  node_t mem [2**AW];
  node_t rdata, mem_wdata;
  logic  mem_we;

  logic signed [SW-1:0] p_a, q_a, ev_a;
  logic [BW-1:0]        p_b, q_b, ev_b;
  logic [CW-1:0]        ev_x, pt_x;
  logic signed [VW-1:0] ev_out, v_p, best;
  logic                 v_lt, v_gt, nd_empty;
  logic                 out_valid;
  logic [BW-1:0]        out_value, sat_value;

  lcmt_line_eval u_eval (
    .clk   (clk),
    .a     (ev_a),
    .b     (ev_b),
    .x     (ev_x),
    .value (ev_out)
  );

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.low_value = out_value;

  assign root_hi  = (range_high < range_low) ? range_low : range_high;
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[XBITS:1];
  assign mid_inc  = mid + XBITS'(1);
  assign v_lt     = (v_p < ev_out);
  assign v_gt     = (v_p > ev_out);
  assign go_right = (state == S_CMP) ? v_gt : (CW'(qx) > CW'(mid));
  assign child    = {idx[AW-2:0], go_right};
  assign child_ovf = idx[AW-1];

  always_comb begin
    unique case (pt)
      PT_L:    pt_x = CW'(lo);
      PT_R:    pt_x = CW'(hi);
      PT_M:    pt_x = CW'(mid);
      default: pt_x = CW'(lo);
    endcase
  end

  always_comb begin
    if (best[VW-1] != best[VW-2]) begin
      sat_value = best[VW-1] ? {1'b1, {(BW-1){1'b0}}} : {1'b0, {(BW-1){1'b1}}};
    end else begin
      sat_value = best[BW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx] <= mem_wdata;
    end
    rdata <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_wdata  = '{empty: 1'b1, slope: '0, intercept: IDENT};
    ev_a       = p_a;
    ev_b       = p_b;
    ev_x       = pt_x;
    unique case (state)
      S_CLR: begin
        mem_we = 1'b1;
        if (&idx) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          case (op_t'(req.op))
            OP_INSERT: state_next = S_IRD;
            OP_QUERY:  state_next = S_QRD;
            OP_CLEAR:  state_next = S_CLR;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_IRD: state_next = S_IDAT;
      S_IDAT: begin
        if (rdata.empty) begin
          mem_we     = 1'b1;
          mem_wdata  = '{empty: 1'b0, slope: q_a, intercept: q_b};
          state_next = S_IDLE;
        end else begin
          state_next = S_EVP;
        end
      end
      S_EVP: state_next = S_EVQ;
      S_EVQ: begin
        ev_a       = q_a;
        ev_b       = q_b;
        state_next = S_W1;
      end
      S_W1: state_next = S_CMP;
      S_CMP: begin
        unique case (pt)
          PT_L: state_next = S_EVP;
          PT_R: begin
            if (!v_lt) begin
              mem_we     = 1'b1;
              mem_wdata  = '{empty: 1'b0, slope: q_a, intercept: q_b};
              state_next = S_IDLE;
            end else begin
              state_next = S_EVP;
            end
          end
          PT_M: begin
            mem_we = 1'b1;
            if (v_gt) begin
              mem_wdata = '{empty: 1'b0, slope: q_a, intercept: q_b};
            end else begin
              mem_wdata = '{empty: 1'b0, slope: p_a, intercept: p_b};
            end
            state_next = child_ovf ? S_IDLE : S_IRD;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_QRD: state_next = S_QDAT;
      S_QDAT: begin
        ev_a       = rdata.slope;
        ev_b       = rdata.intercept;
        ev_x       = CW'(qx);
        state_next = S_QW1;
      end
      S_QW1: state_next = S_QCMP;
      S_QCMP: begin
        if ((lo >= hi) || child_ovf) begin
          state_next = S_QOUT;
        end else begin
          state_next = S_QRD;
        end
      end
      S_QOUT: begin
        if (!out_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      out_valid  <= 1'b0;
      range_low  <= '0;
      range_high <= '1;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_RANGE_LOW) begin
          range_low <= XBITS'(cfg_data);
        end else begin
          range_high <= XBITS'(cfg_data);
        end
      end
      if ((state == S_QOUT) && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: idx <= idx + AW'(1);
        S_IDLE: begin
          if (req.valid) begin
            idx  <= (op_t'(req.op) == OP_CLEAR) ? AW'(0) : AW'(1);
            lo   <= range_low;
            hi   <= root_hi;
            q_a  <= req.slope;
            q_b  <= req.intercept;
            qx   <= req.query_x;
            best <= {1'b0, IDENT};
          end
        end
        S_IDAT: begin
          p_a <= rdata.slope;
          p_b <= rdata.intercept;
          pt  <= PT_L;
        end
        S_W1: v_p <= ev_out;
        S_CMP: begin
          unique case (pt)
            PT_L: begin
              if (v_lt) begin
                p_a <= q_a;
                p_b <= q_b;
                q_a <= p_a;
                q_b <= p_b;
              end
              pt <= PT_R;
            end
            PT_R: pt <= PT_M;
            PT_M: begin
              if (v_gt) begin
                q_a <= p_a;
                q_b <= p_b;
                lo  <= mid_inc;
              end else begin
                hi <= mid;
              end
              idx <= child;
            end
            default: pt <= PT_L;
          endcase
        end
        S_QDAT: nd_empty <= rdata.empty;
        S_QCMP: begin
          if (!nd_empty && (ev_out < best)) begin
            best <= ev_out;
          end
          if (lo < hi) begin
            if (go_right) begin
              lo <= mid_inc;
            end else begin
              hi <= mid;
            end
          end
          idx <= child;
        end
        S_QOUT: begin
          if (!out_valid || rsp.ready) begin
            out_value <= sat_value;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_query_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_QRD || state == S_QDAT || state == S_QW1 || state == S_QCMP ||
     state == S_QOUT) |-> !mem_we)
    else $error("node memory written during a query walk");

  a_walk_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_IRD || state == S_QRD) |-> (idx != '0))
    else $error("tree walk reached node index zero");

  a_insert_interval: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVP) |-> (lo <= hi))
    else $error("insert interval became empty");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_QOUT))
    else $error("result loaded outside the query output step");
`endif

endmodule
`default_nettype wire
